/* hdl/pip_pkg.sv */
// Shared types, constants and helpers for the point-in-polygon test core.
// Used by the core, its edge unit and its port checker; depends on nothing.
package pip_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 16;
  localparam int IN_COORD_W   = 16;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int HELD_W       = 5;

  localparam logic [CNT_W-1:0] MIN_VERTS  = CNT_W'(3);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_VERTICES);

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2
  } req_t;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_TOO_FEW  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic signed [IN_COORD_W-1:0] coord_x;
    logic signed [IN_COORD_W-1:0] coord_y;
  } in_t;

  typedef struct packed {
    logic              inside_res;
    logic [HELD_W-1:0] vertices_held;
    logic [1:0]        status;
  } out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } vertex_t;

  // Result of one edge leaving the edge unit.
  typedef struct packed {
    logic vld;
    logic toggle;
    logic last;
  } edge_res_t;

  // Sign-extend or wrap an input coordinate to the internal width.
  function automatic logic signed [COORD_BITS-1:0] coord_in(
    input logic signed [IN_COORD_W-1:0] v
  );
    return COORD_BITS'(v);
  endfunction

endpackage

/* hdl/pip_edge_unit.sv */
// Edge crossing unit: one polygon edge per cycle, two multipliers, one register stage.
// Depends on pip_pkg for the vertex and result types.
module pip_edge_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  pip_pkg::vertex_t   pt,
  input  pip_pkg::vertex_t   cur,
  input  pip_pkg::vertex_t   prev,
  input  logic               edge_vld,
  input  logic               edge_last,
  output pip_pkg::edge_res_t res
);

  logic signed [pip_pkg::DIFF_W-1:0] dx_pt;
  logic signed [pip_pkg::DIFF_W-1:0] dx_edge;
  logic signed [pip_pkg::DIFF_W-1:0] dy_edge;
  logic signed [pip_pkg::DIFF_W-1:0] dy_pt;
  logic signed [pip_pkg::PROD_W-1:0] lhs_nxt;
  logic signed [pip_pkg::PROD_W-1:0] rhs_nxt;
  logic                              straddle_nxt;

  logic signed [pip_pkg::PROD_W-1:0] lhs_r;
  logic signed [pip_pkg::PROD_W-1:0] rhs_r;
  logic                              straddle_r;
  logic                              dy_pos_r;
  logic                              vld_r;
  logic                              last_r;
  logic                              left;

  always_comb begin
    dx_pt        = pip_pkg::DIFF_W'(pt.x) - pip_pkg::DIFF_W'(cur.x);
    dx_edge      = pip_pkg::DIFF_W'(prev.x) - pip_pkg::DIFF_W'(cur.x);
    dy_edge      = pip_pkg::DIFF_W'(prev.y) - pip_pkg::DIFF_W'(cur.y);
    dy_pt        = pip_pkg::DIFF_W'(pt.y) - pip_pkg::DIFF_W'(cur.y);
    lhs_nxt      = pip_pkg::PROD_W'(dx_pt) * pip_pkg::PROD_W'(dy_edge);
    rhs_nxt      = pip_pkg::PROD_W'(dx_edge) * pip_pkg::PROD_W'(dy_pt);
    straddle_nxt = (cur.y > pt.y) != (prev.y > pt.y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      last_r <= 1'b0;
    end else begin
      vld_r  <= edge_vld;
      last_r <= edge_vld & edge_last;
    end
  end

  always_ff @(posedge clk) begin
    if (edge_vld) begin
      lhs_r      <= lhs_nxt;
      rhs_r      <= rhs_nxt;
      straddle_r <= straddle_nxt;
      dy_pos_r   <= dy_edge > 0;
    end
  end

  // The sign of the edge's y difference sets the direction of the comparison.
  assign left       = dy_pos_r ? (lhs_r < rhs_r) : (lhs_r > rhs_r);
  assign res.vld    = vld_r;
  assign res.last   = last_r;
  assign res.toggle = vld_r & straddle_r & left;

endmodule

/* hdl/point_in_polygon_test_core.sv */
// Even-odd point-in-polygon test core: vertex memory, query sequencer, result register.
// Depends on pip_pkg and pip_edge_unit.

// Each transaction clears the polygon, appends a vertex or queries a point. Clear,
// append, the unused request code and a query on fewer than three vertices keep busy
// low, and the result strobe comes in the cycle after acceptance. A query on three
// or more vertices raises busy while it walks the polygon: the vertex memory has one
// read port, the closing edge's start is read in the accepting cycle, the walk then
// reads one edge endpoint per cycle, and the edge unit's multiply and compare
// follow. The result strobe comes in the first cycle that busy is low again. Results
// are marked by out_valid for exactly one cycle on out_data, and cannot be held off;
// a new transaction may be accepted in the same cycle as a strobe. Vertex memory
// contents are undefined until written.
module point_in_polygon_test_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  pip_pkg::in_t   in_data,
  output logic           out_valid,
  output pip_pkg::out_t  out_data
);

  pip_pkg::vertex_t vmem [pip_pkg::MAX_VERTICES];

  pip_pkg::state_t              state_r, state_nxt;
  logic [pip_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [pip_pkg::IDX_W-1:0]    k_r, k_nxt;
  logic [pip_pkg::IDX_W-1:0]    last_idx;
  logic [pip_pkg::IDX_W-1:0]    rd_addr;
  pip_pkg::vertex_t             rd_data_r;
  pip_pkg::vertex_t             prev_r;
  pip_pkg::vertex_t             pt_r;
  pip_pkg::vertex_t             in_vtx;
  logic                         rd_first_r;
  logic                         rd_edge_r;
  logic                         rd_last_r;
  logic                         issue_edge;
  logic                         inside_r, inside_nxt;
  logic                         out_valid_r, out_valid_nxt;
  pip_pkg::out_t                out_data_r, out_data_nxt;
  logic                         accept;
  logic                         is_query;
  logic                         wr_en;
  logic                         full;
  pip_pkg::edge_res_t           edge_res;

  assign accept   = start & ~busy;
  assign is_query = in_data.req_type == pip_pkg::REQ_QUERY;
  assign full     = count_r == pip_pkg::FULL_COUNT;
  assign wr_en    = accept & (in_data.req_type == pip_pkg::REQ_APPEND) & ~full;
  assign last_idx = pip_pkg::IDX_W'(count_r - 1'b1);
  assign in_vtx.x = pip_pkg::coord_in(in_data.coord_x);
  assign in_vtx.y = pip_pkg::coord_in(in_data.coord_y);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pip_pkg::ST_IDLE: begin
        if (accept && is_query && count_r >= pip_pkg::MIN_VERTS) begin
          state_nxt = pip_pkg::ST_WALK;
        end
      end
      pip_pkg::ST_WALK: begin
        if (k_r == last_idx) begin
          state_nxt = pip_pkg::ST_DRAIN;
        end
      end
      pip_pkg::ST_DRAIN: begin
        if (edge_res.vld && edge_res.last) begin
          state_nxt = pip_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pip_pkg::ST_IDLE;
    endcase
  end

  // State outputs. While idle the address points at the closing edge's start vertex.
  always_comb begin
    busy       = 1'b1;
    issue_edge = 1'b0;
    rd_addr    = last_idx;
    unique case (state_r)
      pip_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      pip_pkg::ST_WALK: begin
        issue_edge = 1'b1;
        rd_addr    = k_r;
      end
      pip_pkg::ST_DRAIN: begin
        busy = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  assign k_nxt = issue_edge ? k_r + 1'b1 : '0;

  // Count, running flag and result register.
  always_comb begin
    count_nxt     = count_r;
    inside_nxt    = inside_r ^ edge_res.toggle;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_data_nxt.inside_res = 1'b0;
      out_data_nxt.status     = pip_pkg::STAT_OK;
      unique case (in_data.req_type)
        pip_pkg::REQ_CLEAR: begin
          count_nxt = '0;
        end
        pip_pkg::REQ_APPEND: begin
          if (full) begin
            out_data_nxt.status = pip_pkg::STAT_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        pip_pkg::REQ_QUERY: begin
          if (count_r < pip_pkg::MIN_VERTS) begin
            out_data_nxt.status = pip_pkg::STAT_TOO_FEW;
          end
          inside_nxt = 1'b0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
      out_data_nxt.vertices_held = pip_pkg::HELD_W'(count_nxt);
      // A query that walks the polygon reports at the end of the walk.
      out_valid_nxt = ~(is_query && count_r >= pip_pkg::MIN_VERTS);
    end else if (edge_res.vld && edge_res.last) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.inside_res    = inside_nxt;
      out_data_nxt.vertices_held = pip_pkg::HELD_W'(count_r);
      out_data_nxt.status        = pip_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pip_pkg::ST_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      inside_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rd_first_r  <= 1'b0;
      rd_edge_r   <= 1'b0;
      rd_last_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      inside_r    <= inside_nxt;
      out_valid_r <= out_valid_nxt;
      rd_first_r  <= accept & is_query & (count_r >= pip_pkg::MIN_VERTS);
      rd_edge_r   <= issue_edge;
      rd_last_r   <= issue_edge & (k_r == last_idx);
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept && is_query) begin
      pt_r <= in_vtx;
    end
    if (rd_first_r || rd_edge_r) begin
      prev_r <= rd_data_r;
    end
  end

  // Vertex memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[count_r[pip_pkg::IDX_W-1:0]] <= in_vtx;
    end
    rd_data_r <= vmem[rd_addr];
  end

  pip_edge_unit u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .pt        (pt_r),
    .cur       (rd_data_r),
    .prev      (prev_r),
    .edge_vld  (rd_edge_r),
    .edge_last (rd_last_r),
    .res       (edge_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/pip_checker.sv */
// Port-level checker for the point-in-polygon test core, bound to the top level.
// Depends on pip_pkg and point_in_polygon_test_core.
module pip_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input pip_pkg::in_t  in_data,
  input logic          out_valid,
  input pip_pkg::out_t out_data
);

  // A clear, append or unused code answers in the very next cycle.
  a_short_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.req_type != pip_pkg::REQ_QUERY |=> out_valid)
    else $error("short transaction did not return a result in the next cycle");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.req_type == pip_pkg::REQ_CLEAR
    |=> out_data.vertices_held == '0)
    else $error("clear did not report an empty polygon");

  a_inside_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.inside_res
    |-> out_data.status == pip_pkg::STAT_OK && out_data.vertices_held >= 5'd3)
    else $error("inside reported without a valid polygon");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start) && $past(in_data.req_type) == pip_pkg::REQ_QUERY)
    else $error("busy rose without an accepted query");

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy && $past(busy) |-> !out_valid)
    else $error("result strobe while a query walk is in progress");

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

/* sim/point_in_polygon_test_core_test.sv */
// Self-checking bench for point_in_polygon_test_core: directed table, then random polygons.
// Depends on pip_pkg (hdl/pip_pkg.sv) and the core; predicts in-line what the table lacks.
`timescale 1ns / 100ps

module point_in_polygon_test_core_test;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 860;
  localparam int TAIL_CYCLES = 30;

  typedef struct {
    pip_pkg::in_t  item;
    int            reps;
    bit            known;
    pip_pkg::out_t lit;
  } table_row_t;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  pip_pkg::in_t   in_data;
  logic           out_valid;
  pip_pkg::out_t  out_data;

  // Predictor copy of the polygon store.
  logic signed [pip_pkg::COORD_BITS-1:0] poly_x [pip_pkg::MAX_VERTICES];
  logic signed [pip_pkg::COORD_BITS-1:0] poly_y [pip_pkg::MAX_VERTICES];
  int poly_count;

  pip_pkg::out_t pending_verdicts[$];
  table_row_t    directed_rows[$];
  int            error_count;
  int            idle_mode;

  point_in_polygon_test_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("point_in_polygon_test_core_test: errors");
    $finish;
  end

  function automatic pip_pkg::in_t make_item(logic [1:0] code, int x, int y);
    pip_pkg::in_t it;
    it.req_type = code;
    it.coord_x  = pip_pkg::IN_COORD_W'(x);
    it.coord_y  = pip_pkg::IN_COORD_W'(y);
    return it;
  endfunction

  function automatic pip_pkg::out_t verdict(logic ins, int held, logic [1:0] stat);
    pip_pkg::out_t v;
    v.inside_res    = ins;
    v.vertices_held = pip_pkg::HELD_W'(held);
    v.status        = stat;
    return v;
  endfunction

  function automatic table_row_t row(logic [1:0] code, int x, int y, int reps,
                                     bit known, pip_pkg::out_t lit);
    table_row_t r;
    r.item  = make_item(code, x, y);
    r.reps  = reps;
    r.known = known;
    r.lit   = lit;
    return r;
  endfunction

  function automatic void add_row(table_row_t r);
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void queue_verdict(pip_pkg::out_t v);
    pending_verdicts = {pending_verdicts, v};
  endfunction

  // Even-odd crossing test over the stored edges, exact by cross-multiplication.
  function automatic logic crossing_parity(longint qx, longint qy);
    logic   ins;
    int     i;
    int     j;
    longint xi, yi, xj, yj, dy, lhs, rhs;
    bit     left;
    ins = 1'b0;
    j = poly_count - 1;
    for (i = 0; i < poly_count; i++) begin
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      if ((yi > qy) != (yj > qy)) begin
        dy  = yj - yi;
        lhs = (qx - xi) * dy;
        rhs = (xj - xi) * (qy - yi);
        left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
        if (left) ins = ~ins;
      end
      j = i;
    end
    return ins;
  endfunction

  // Applies one request to the predictor state and returns its verdict.
  function automatic pip_pkg::out_t apply_request(pip_pkg::in_t item);
    logic signed [pip_pkg::COORD_BITS-1:0] cx;
    logic signed [pip_pkg::COORD_BITS-1:0] cy;
    logic       ins;
    logic [1:0] stat;
    cx   = pip_pkg::coord_in(item.coord_x);
    cy   = pip_pkg::coord_in(item.coord_y);
    ins  = 1'b0;
    stat = pip_pkg::STAT_OK;
    case (item.req_type)
      pip_pkg::REQ_CLEAR: begin
        poly_count = 0;
      end
      pip_pkg::REQ_APPEND: begin
        if (poly_count >= pip_pkg::MAX_VERTICES) begin
          stat = pip_pkg::STAT_FULL;
        end else begin
          poly_x[poly_count] = cx;
          poly_y[poly_count] = cy;
          poly_count++;
        end
      end
      pip_pkg::REQ_QUERY: begin
        if (poly_count < 3) stat = pip_pkg::STAT_TOO_FEW;
        else ins = crossing_parity(cx, cy);
      end
      default: ;
    endcase
    return verdict(ins, poly_count, stat);
  endfunction

  function automatic int draw_gap();
    case (idle_mode)
      0: return 0;
      1: return $urandom_range(0, 13);
      default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
    endcase
  endfunction

  function automatic int rand_coord(int span);
    if (span >= 32768) return $urandom_range(0, 65535) - 32768;
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Query: one in ten anywhere, else in the polygon's box, on a vertex row or on a vertex.
  function automatic pip_pkg::in_t pick_query();
    longint lo_x, hi_x, lo_y, hi_y;
    int     k;
    int     pick;
    int     qx, qy;
    if (poly_count == 0 || $urandom_range(0, 9) == 0)
      return make_item(pip_pkg::REQ_QUERY, rand_coord(32768), rand_coord(32768));
    lo_x = poly_x[0]; hi_x = poly_x[0];
    lo_y = poly_y[0]; hi_y = poly_y[0];
    for (k = 1; k < poly_count; k++) begin
      if (poly_x[k] < lo_x) lo_x = poly_x[k];
      if (poly_x[k] > hi_x) hi_x = poly_x[k];
      if (poly_y[k] < lo_y) lo_y = poly_y[k];
      if (poly_y[k] > hi_y) hi_y = poly_y[k];
    end
    lo_x = (lo_x - 2 < -32768) ? -32768 : lo_x - 2;
    lo_y = (lo_y - 2 < -32768) ? -32768 : lo_y - 2;
    hi_x = (hi_x + 2 > 32767) ? 32767 : hi_x + 2;
    hi_y = (hi_y + 2 > 32767) ? 32767 : hi_y + 2;
    qx = int'(lo_x) + $urandom_range(0, int'(hi_x - lo_x));
    qy = int'(lo_y) + $urandom_range(0, int'(hi_y - lo_y));
    pick = $urandom_range(0, 5);
    k = $urandom_range(0, poly_count - 1);
    if (pick == 0) begin
      qx = poly_x[k];
      qy = poly_y[k];
    end else if (pick == 1) begin
      qy = poly_y[k];
    end
    return make_item(pip_pkg::REQ_QUERY, qx, qy);
  endfunction

  // One transaction: optional idle cycles, then hold start until the core takes it.
  task automatic send_request(input pip_pkg::in_t item, input bit use_lit,
                              input pip_pkg::out_t lit);
    pip_pkg::out_t predicted;
    int            gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_request(item);
    queue_verdict(use_lit ? lit : predicted);
  endtask

  task automatic report_field(input string name, input int want, input int got);
    error_count++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
  endtask

  always @(posedge clk) begin : result_watch
    pip_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none actual %p", $time, out_data);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data.inside_res !== want.inside_res)
          report_field("inside_res", want.inside_res, out_data.inside_res);
        if (out_data.vertices_held !== want.vertices_held)
          report_field("vertices_held", want.vertices_held, out_data.vertices_held);
        if (out_data.status !== want.status)
          report_field("status", want.status, out_data.status);
      end
    end
  end

  initial begin : stimulus
    int            r;
    int            k;
    int            sent;
    int            n_app;
    int            n_query;
    int            span;
    int            kind;
    pip_pkg::out_t none;
    none        = '0;
    error_count = 0;
    idle_mode   = 0;
    poly_count  = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(row(pip_pkg::REQ_QUERY, 0, 0, 1, 1, verdict(0, 0, pip_pkg::STAT_TOO_FEW)));
    add_row(row(REQ_UNUSED, 32767, -1, 1, 1, verdict(0, 0, pip_pkg::STAT_OK)));
    add_row(row(pip_pkg::REQ_CLEAR, -1, 32767, 1, 1, verdict(0, 0, pip_pkg::STAT_OK)));
    add_row(row(pip_pkg::REQ_APPEND, -32768, -32768, 1, 1,
                verdict(0, 1, pip_pkg::STAT_OK)));
    add_row(row(pip_pkg::REQ_APPEND, 32767, -32768, 1, 1,
                verdict(0, 2, pip_pkg::STAT_OK)));
    add_row(row(pip_pkg::REQ_QUERY, 0, 0, 1, 1, verdict(0, 2, pip_pkg::STAT_TOO_FEW)));
    add_row(row(pip_pkg::REQ_APPEND, 32767, 32767, 1, 1,
                verdict(0, 3, pip_pkg::STAT_OK)));
    add_row(row(pip_pkg::REQ_QUERY, 0, 0, 1, 0, none));
    add_row(row(pip_pkg::REQ_APPEND, -32768, 32767, 1, 1,
                verdict(0, 4, pip_pkg::STAT_OK)));
    add_row(row(pip_pkg::REQ_QUERY, 0, 0, 1, 0, none));
    add_row(row(pip_pkg::REQ_QUERY, -32768, -32768, 1, 0, none));
    add_row(row(pip_pkg::REQ_QUERY, 32767, 0, 1, 0, none));
    add_row(row(pip_pkg::REQ_QUERY, -32768, 0, 1, 0, none));
    add_row(row(pip_pkg::REQ_QUERY, 0, 32767, 1, 0, none));
    add_row(row(pip_pkg::REQ_QUERY, 0, -32768, 1, 0, none));
    add_row(row(REQ_UNUSED, 1, 1, 1, 1, verdict(0, 4, pip_pkg::STAT_OK)));
    add_row(row(pip_pkg::REQ_CLEAR, 0, 0, 1, 1, verdict(0, 0, pip_pkg::STAT_OK)));
    add_row(row(pip_pkg::REQ_APPEND, 256, 0, 1, 0, none));
    add_row(row(pip_pkg::REQ_APPEND, 0, 512, 1, 0, none));
    add_row(row(pip_pkg::REQ_APPEND, -256, -256, 1, 0, none));
    add_row(row(pip_pkg::REQ_QUERY, 0, 0, 1, 0, none));
    add_row(row(pip_pkg::REQ_QUERY, 0, 512, 1, 0, none));
    // Fill the store to the top, then one append past it.
    add_row(row(pip_pkg::REQ_APPEND, 10, 10, 13, 0, none));
    add_row(row(pip_pkg::REQ_APPEND, 1, 2, 1, 1, verdict(0, 16, pip_pkg::STAT_FULL)));
    add_row(row(pip_pkg::REQ_QUERY, 5, 5, 1, 0, none));
    add_row(row(pip_pkg::REQ_CLEAR, 0, 0, 1, 1, verdict(0, 0, pip_pkg::STAT_OK)));

    for (r = 0; r < directed_rows.size(); r++) begin
      idle_mode = $urandom_range(0, 2);
      for (k = 0; k < directed_rows[r].reps; k++)
        send_request(directed_rows[r].item, directed_rows[r].known, directed_rows[r].lit);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_mode = $urandom_range(0, 2);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // Well-formed polygon: clear, vertices, then a run of queries.
        case ($urandom_range(0, 3))
          0: span = 32768;
          1: span = 8;
          default: span = 256;
        endcase
        n_app = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 18) : $urandom_range(3, 10);
        n_query = $urandom_range(4, 10);
        send_request(make_item(pip_pkg::REQ_CLEAR, rand_coord(32768), rand_coord(32768)),
                     0, none);
        for (k = 0; k < n_app; k++)
          send_request(make_item(pip_pkg::REQ_APPEND, rand_coord(span), rand_coord(span)),
                       0, none);
        for (k = 0; k < n_query; k++)
          send_request(pick_query(), 0, none);
        sent += 1 + n_app + n_query;
      end else if (kind < 9) begin
        // Noise: any request code, any coordinates, on top of whatever is stored.
        n_app = $urandom_range(3, 12);
        for (k = 0; k < n_app; k++)
          send_request(make_item(2'($urandom_range(0, 3)), rand_coord(32768),
                                 rand_coord(32768)), 0, none);
        sent += n_app;
      end else begin
        // Broken polygon: too few vertices before the query.
        n_app = $urandom_range(0, 2);
        send_request(make_item(pip_pkg::REQ_CLEAR, 0, 0), 0, none);
        for (k = 0; k < n_app; k++)
          send_request(make_item(pip_pkg::REQ_APPEND, rand_coord(32768),
                                 rand_coord(32768)), 0, none);
        send_request(pick_query(), 0, none);
        sent += 2 + n_app;
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("point_in_polygon_test_core_test: clean");
    end else begin
      $display("point_in_polygon_test_core_test: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/pip_pkg.sv
hdl/pip_edge_unit.sv
hdl/point_in_polygon_test_core.sv
hdl/pip_checker.sv
sim/point_in_polygon_test_core_test.sv
